// ===== hw/rtl/durs_pkg.sv =====
package durs_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_CLOSE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_TRIGGER_TICKS   = 3'd1;
    localparam logic [2:0] REG_SENSOR_GAP      = 3'd2;
    localparam logic [2:0] REG_ROUND_GAP       = 3'd3;
    localparam logic [2:0] REG_TICKS_PER_CM    = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int DIST_W      = 10;
    localparam int GAP_W       = 20;

    localparam int MAX_DISTANCE_CM_DEFAULT = 1023;

    // Reset values of the configuration registers.
    localparam logic [9:0]  RST_CLOSE_THRESHOLD = 10'd40;
    localparam logic [7:0]  RST_TRIGGER_TICKS   = 8'd10;
    localparam logic [7:0]  RST_SENSOR_GAP      = 8'd10;
    localparam logic [19:0] RST_ROUND_GAP       = 20'd500000;
    localparam logic [7:0]  RST_TICKS_PER_CM    = 8'd58;

    typedef struct packed {
        logic [9:0]  close_threshold_cm;
        logic [7:0]  trigger_ticks;
        logic [7:0]  sensor_gap_ticks;
        logic [19:0] round_gap_ticks;
        logic [7:0]  ticks_per_cm;
    } t_cfg;

    typedef struct packed {
        logic       trigger_first;
        logic       trigger_second;
        logic [9:0] distance_cm;
        logic       distance_valid;
        logic       sensor_index;
        logic       stop;
    } t_result;

endpackage

// ===== hw/rtl/durs_cfg.sv =====
module durs_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [durs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [durs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output durs_pkg::t_cfg                    o_cfg
);

    durs_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Writes to an index past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.close_threshold_cm <= durs_pkg::RST_CLOSE_THRESHOLD;
            r_cfg.trigger_ticks      <= durs_pkg::RST_TRIGGER_TICKS;
            r_cfg.sensor_gap_ticks   <= durs_pkg::RST_SENSOR_GAP;
            r_cfg.round_gap_ticks    <= durs_pkg::RST_ROUND_GAP;
            r_cfg.ticks_per_cm       <= durs_pkg::RST_TICKS_PER_CM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                durs_pkg::REG_CLOSE_THRESHOLD: begin
                    r_cfg.close_threshold_cm <= i_cfg_data[9:0];
                end
                durs_pkg::REG_TRIGGER_TICKS: begin
                    r_cfg.trigger_ticks <= i_cfg_data[7:0];
                end
                durs_pkg::REG_SENSOR_GAP: begin
                    r_cfg.sensor_gap_ticks <= i_cfg_data[7:0];
                end
                durs_pkg::REG_ROUND_GAP: begin
                    r_cfg.round_gap_ticks <= i_cfg_data[19:0];
                end
                durs_pkg::REG_TICKS_PER_CM: begin
                    r_cfg.ticks_per_cm <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/durs_seq.sv =====
module durs_seq #(
    parameter int MAX_DISTANCE_CM = durs_pkg::MAX_DISTANCE_CM_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  durs_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_echo_first,
    input  logic              i_echo_second,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output durs_pkg::t_result o_res
);

    localparam int DW = $clog2(MAX_DISTANCE_CM + 1);
    localparam int CW = (DW > durs_pkg::DIST_W) ? DW : durs_pkg::DIST_W;
    localparam logic [DW-1:0] DIST_MAX = DW'(MAX_DISTANCE_CM);

    typedef enum logic [3:0] {
        PH_TRIG1 = 4'd0,
        PH_WAIT1 = 4'd1,
        PH_TIME1 = 4'd2,
        PH_GAP   = 4'd3,
        PH_TRIG2 = 4'd4,
        PH_WAIT2 = 4'd5,
        PH_TIME2 = 4'd6,
        PH_ROUND = 4'd7,
        PH_HALT  = 4'd8
    } t_phase;

    t_phase                             r_phase, n_phase;
    logic [durs_pkg::GAP_W-1:0]         r_cnt, n_cnt;
    logic [7:0]                         r_sub, n_sub;
    logic [DW-1:0]                      r_dist, n_dist;
    logic                               r_stopped, n_stopped;
    logic [durs_pkg::DIST_W-1:0]        r_last_dist, n_last_dist;
    logic                               r_last_sensor, n_last_sensor;
    logic                               r_out_valid;
    durs_pkg::t_result                  r_res;

    logic                               accept;
    logic                               t1, t2, meas_valid;
    logic [durs_pkg::GAP_W-1:0]         cnt_inc;
    logic [7:0]                         sub_base, sub_inc;
    logic [DW-1:0]                      dist_base, dist_cnt;
    logic                               echo_sel;
    logic [CW-1:0]                      dist_ext;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    assign cnt_inc  = r_cnt + 1'b1;
    assign dist_ext = CW'(r_dist);
    assign echo_sel = (r_phase == PH_WAIT2 || r_phase == PH_TIME2) ? i_echo_second
                                                                    : i_echo_first;

    // One echo tick of the counting divider; a wait phase restarts it from zero.
    always_comb begin
        sub_base  = (r_phase == PH_WAIT1 || r_phase == PH_WAIT2) ? 8'd0 : r_sub;
        dist_base = (r_phase == PH_WAIT1 || r_phase == PH_WAIT2) ? '0 : r_dist;
        sub_inc   = sub_base + 8'd1;
        dist_cnt  = dist_base;
        if (sub_inc >= i_cfg.ticks_per_cm || sub_inc == 8'd0) begin
            sub_inc = 8'd0;
            if (dist_base < DIST_MAX) begin
                dist_cnt = dist_base + 1'b1;
            end
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_sub         = r_sub;
        n_dist        = r_dist;
        n_stopped     = r_stopped;
        n_last_dist   = r_last_dist;
        n_last_sensor = r_last_sensor;
        t1            = 1'b0;
        t2            = 1'b0;
        meas_valid    = 1'b0;
        case (r_phase)
            PH_TRIG1, PH_TRIG2: begin
                t1    = (r_phase == PH_TRIG1);
                t2    = (r_phase == PH_TRIG2);
                n_cnt = cnt_inc;
                if (cnt_inc >= durs_pkg::GAP_W'(i_cfg.trigger_ticks)) begin
                    n_cnt   = '0;
                    n_phase = (r_phase == PH_TRIG2) ? PH_WAIT2 : PH_WAIT1;
                end
            end
            PH_WAIT1, PH_WAIT2: begin
                if (echo_sel) begin
                    n_sub   = sub_inc;
                    n_dist  = dist_cnt;
                    n_phase = (r_phase == PH_WAIT2) ? PH_TIME2 : PH_TIME1;
                end
            end
            PH_TIME1, PH_TIME2: begin
                if (echo_sel) begin
                    n_sub  = sub_inc;
                    n_dist = dist_cnt;
                end else begin
                    meas_valid    = 1'b1;
                    n_last_dist   = dist_ext[durs_pkg::DIST_W-1:0];
                    n_last_sensor = (r_phase == PH_TIME2);
                    n_cnt         = '0;
                    if (dist_ext < CW'(i_cfg.close_threshold_cm)) begin
                        n_stopped = 1'b1;
                        n_phase   = PH_HALT;
                    end else if (r_phase == PH_TIME2) begin
                        n_phase = (i_cfg.round_gap_ticks == '0) ? PH_TRIG1 : PH_ROUND;
                    end else begin
                        n_phase = (i_cfg.sensor_gap_ticks == 8'd0) ? PH_TRIG2 : PH_GAP;
                    end
                end
            end
            PH_GAP: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= durs_pkg::GAP_W'(i_cfg.sensor_gap_ticks)) begin
                    n_cnt   = '0;
                    n_phase = PH_TRIG2;
                end
            end
            PH_ROUND: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.round_gap_ticks) begin
                    n_cnt   = '0;
                    n_phase = PH_TRIG1;
                end
            end
            PH_HALT: begin
            end
            default: begin
                n_phase = PH_TRIG1;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TRIG1;
            r_cnt         <= '0;
            r_sub         <= '0;
            r_dist        <= '0;
            r_stopped     <= 1'b0;
            r_last_dist   <= '0;
            r_last_sensor <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_cnt         <= n_cnt;
                r_sub         <= n_sub;
                r_dist        <= n_dist;
                r_stopped     <= n_stopped;
                r_last_dist   <= n_last_dist;
                r_last_sensor <= n_last_sensor;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res.trigger_first  <= t1;
            r_res.trigger_second <= t2;
            r_res.distance_cm    <= n_last_dist;
            r_res.distance_valid <= meas_valid;
            r_res.sensor_index   <= n_last_sensor;
            r_res.stop           <= n_stopped;
        end
    end

endmodule

// ===== hw/rtl/dual_ultrasonic_range_stop_top.sv =====
// Two-sensor ultrasonic ranger with a sticky stop flag. Every input beat is
// one microsecond tick carrying both echo line levels, and every input beat
// yields exactly one output beat carrying both trigger levels, the last
// completed distance in centimeters with its sensor, a one-tick completion
// flag and the stop flag. The sensors are ranged in turn: trigger pulse,
// wait for the echo to rise, time the echo with a counting divider by
// ticks_per_cm, then a short gap before the second sensor and a long gap
// before the next round. A reading below the threshold halts ranging until
// reset. The echo waits have no timeout. Throughput is one beat per clock
// unless stalled: the phase sequencer is a single register stage that advances
// once per accepted beat, and the output register lets a new beat in on the
// same cycle the previous result is taken. The user writes configuration
// through the register port while no beat is in flight; this is not enforced.
module dual_ultrasonic_range_stop_top #(
    parameter int MAX_DISTANCE_CM = durs_pkg::MAX_DISTANCE_CM_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] echo_first, [1] echo_second, [7:2] zero
    input  logic [7:0]                        s_axis_tdata,
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] trigger_first, [1] trigger_second, [11:2] distance_cm,
    // [12] distance_valid, [13] stop, [15:14] zero
    output logic [15:0]                       m_axis_tdata,
    // [0] sensor_index
    output logic                              m_axis_tuser,
    // Configuration write port.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [durs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [durs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    durs_pkg::t_cfg    cfg;
    durs_pkg::t_result res;

    durs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    durs_seq #(
        .MAX_DISTANCE_CM (MAX_DISTANCE_CM)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_echo_first  (s_axis_tdata[0]),
        .i_echo_second (s_axis_tdata[1]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_res         (res)
    );

    // Padding bits of the input beat are not used.
    assign m_axis_tdata = {2'b00, res.stop, res.distance_valid, res.distance_cm,
                           res.trigger_second, res.trigger_first};
    assign m_axis_tuser = res.sensor_index;

endmodule

// ===== tb/range_stop_checker.sv =====
`timescale 1ns / 1ps

// Watches the stream and register channels of the ranger. It keeps its own
// copy of the sequencer state and the register settings, predicts one output
// beat for each accepted input beat, and compares each accepted output beat
// with the oldest prediction.
module range_stop_checker #(
    parameter int MAX_CM = durs_pkg::MAX_DISTANCE_CM_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [7:0]                        i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [15:0]                       i_out_data,
    input  logic                              i_out_user,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [durs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [durs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_readings,
    output int                                o_saturated,
    output logic                              o_halted
);

    typedef enum logic [3:0] {
        RNG_TRIG_A,
        RNG_WAIT_A,
        RNG_TIME_A,
        RNG_SENSOR_GAP,
        RNG_TRIG_B,
        RNG_WAIT_B,
        RNG_TIME_B,
        RNG_ROUND_GAP,
        RNG_HALTED
    } t_rng_phase;

    durs_pkg::t_cfg    cfg;
    t_rng_phase        phase;
    logic [19:0]       phase_cnt;
    logic [7:0]        sub_cnt;
    logic [15:0]       dist_cnt;
    logic              stopped;
    logic [9:0]        last_dist;
    logic              last_sensor;

    durs_pkg::t_result predicted_beats[$];
    int                out_idx;

    // One high echo tick: the sub-counter divides by ticks_per_cm.
    task automatic count_echo_tick();
        begin
            sub_cnt = sub_cnt + 8'd1;
            if (sub_cnt >= cfg.ticks_per_cm || sub_cnt == 8'd0) begin
                sub_cnt = 8'd0;
                if (dist_cnt < MAX_CM) begin
                    dist_cnt = dist_cnt + 16'd1;
                end
            end
        end
    endtask

    task automatic range_tick(input logic echo_a, input logic echo_b,
                              output durs_pkg::t_result res);
        logic is_b;
        logic echo;
        logic done;
        begin
            res  = '0;
            done = 1'b0;
            case (phase)
                RNG_TRIG_A, RNG_TRIG_B: begin
                    is_b = (phase == RNG_TRIG_B);
                    if (is_b) begin
                        res.trigger_second = 1'b1;
                    end else begin
                        res.trigger_first = 1'b1;
                    end
                    phase_cnt = phase_cnt + 20'd1;
                    if (phase_cnt >= {12'd0, cfg.trigger_ticks}) begin
                        phase_cnt = '0;
                        phase = is_b ? RNG_WAIT_B : RNG_WAIT_A;
                    end
                end
                RNG_WAIT_A, RNG_WAIT_B: begin
                    is_b = (phase == RNG_WAIT_B);
                    echo = is_b ? echo_b : echo_a;
                    if (echo) begin
                        sub_cnt  = '0;
                        dist_cnt = '0;
                        count_echo_tick();
                        phase = is_b ? RNG_TIME_B : RNG_TIME_A;
                    end
                end
                RNG_TIME_A, RNG_TIME_B: begin
                    is_b = (phase == RNG_TIME_B);
                    echo = is_b ? echo_b : echo_a;
                    if (echo) begin
                        count_echo_tick();
                    end else begin
                        done        = 1'b1;
                        last_dist   = dist_cnt[9:0];
                        last_sensor = is_b;
                        if (dist_cnt < {6'd0, cfg.close_threshold_cm}) begin
                            stopped = 1'b1;
                            phase   = RNG_HALTED;
                        end else if (is_b) begin
                            phase_cnt = '0;
                            phase = (cfg.round_gap_ticks == '0) ? RNG_TRIG_A : RNG_ROUND_GAP;
                        end else begin
                            phase_cnt = '0;
                            phase = (cfg.sensor_gap_ticks == '0) ? RNG_TRIG_B : RNG_SENSOR_GAP;
                        end
                    end
                end
                RNG_SENSOR_GAP, RNG_ROUND_GAP: begin
                    is_b = (phase == RNG_ROUND_GAP);
                    phase_cnt = phase_cnt + 20'd1;
                    if (phase_cnt >= (is_b ? cfg.round_gap_ticks
                                           : {12'd0, cfg.sensor_gap_ticks})) begin
                        phase_cnt = '0;
                        phase = is_b ? RNG_TRIG_A : RNG_TRIG_B;
                    end
                end
                RNG_HALTED: begin
                end
                default: begin
                    phase     = RNG_TRIG_A;
                    phase_cnt = '0;
                end
            endcase
            res.distance_cm    = last_dist;
            res.distance_valid = done;
            res.sensor_index   = last_sensor;
            res.stop           = stopped;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        durs_pkg::t_result exp_r;
        durs_pkg::t_result act_r;
        if (!i_rst_n) begin
            cfg.close_threshold_cm = durs_pkg::RST_CLOSE_THRESHOLD;
            cfg.trigger_ticks      = durs_pkg::RST_TRIGGER_TICKS;
            cfg.sensor_gap_ticks   = durs_pkg::RST_SENSOR_GAP;
            cfg.round_gap_ticks    = durs_pkg::RST_ROUND_GAP;
            cfg.ticks_per_cm       = durs_pkg::RST_TICKS_PER_CM;
            phase       = RNG_TRIG_A;
            phase_cnt   = '0;
            sub_cnt     = '0;
            dist_cnt    = '0;
            stopped     = 1'b0;
            last_dist   = '0;
            last_sensor = 1'b0;
            predicted_beats.delete();
            out_idx     = 0;
            o_errors    <= 0;
            o_readings  <= 0;
            o_saturated <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    durs_pkg::REG_CLOSE_THRESHOLD:
                        cfg.close_threshold_cm = i_cfg_data[9:0];
                    durs_pkg::REG_TRIGGER_TICKS:
                        cfg.trigger_ticks      = i_cfg_data[7:0];
                    durs_pkg::REG_SENSOR_GAP:
                        cfg.sensor_gap_ticks   = i_cfg_data[7:0];
                    durs_pkg::REG_ROUND_GAP:
                        cfg.round_gap_ticks    = i_cfg_data[19:0];
                    durs_pkg::REG_TICKS_PER_CM:
                        cfg.ticks_per_cm       = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end

            // Outputs are handled before inputs: a beat taken at this edge was
            // predicted at an earlier one.
            if (i_out_valid && i_out_ready) begin
                act_r.trigger_first  = i_out_data[0];
                act_r.trigger_second = i_out_data[1];
                act_r.distance_cm    = i_out_data[11:2];
                act_r.distance_valid = i_out_data[12];
                act_r.stop           = i_out_data[13];
                act_r.sensor_index   = i_out_user;
                if (predicted_beats.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) begin
                        $display("Output beat %0d arrived with no input beat behind it", out_idx);
                    end
                end else begin
                    exp_r = predicted_beats.pop_front();
                    if (act_r !== exp_r) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10) begin
                            $display({"Output beat %0d mismatch (expected/actual): ",
                                      "trig1 %b/%b trig2 %b/%b dist %0d/%0d ",
                                      "valid %b/%b sensor %b/%b stop %b/%b"},
                                     out_idx,
                                     exp_r.trigger_first, act_r.trigger_first,
                                     exp_r.trigger_second, act_r.trigger_second,
                                     exp_r.distance_cm, act_r.distance_cm,
                                     exp_r.distance_valid, act_r.distance_valid,
                                     exp_r.sensor_index, act_r.sensor_index,
                                     exp_r.stop, act_r.stop);
                        end
                    end
                end
                out_idx++;
            end

            if (i_in_valid && i_in_ready) begin
                range_tick(i_in_data[0], i_in_data[1], exp_r);
                predicted_beats.push_back(exp_r);
                if (exp_r.distance_valid) begin
                    o_readings <= o_readings + 1;
                    if (exp_r.distance_cm == MAX_CM[9:0]) begin
                        o_saturated <= o_saturated + 1;
                    end
                end
            end
        end
        o_pending <= predicted_beats.size();
        o_halted  <= stopped;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the two-sensor ranger. The checker beside the
// block does all prediction and comparison; this module only drives beats,
// writes register settings while the block is empty, and reports.
module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 300;
    localparam int RX_QUIET_LO = 1200;
    localparam int RX_QUIET_HI = 1500;
    localparam int IDX_W       = durs_pkg::CFG_INDEX_W;
    localparam int REG_LAST    = int'(durs_pkg::REG_TICKS_PER_CM);
    localparam int IDX_MAX     = (1 << IDX_W) - 1;

    // Short fixed echo pattern, two bits per tick, echo_first in the low bit.
    localparam logic [47:0] DIRECTED_TICKS = 48'h1BE472D836C9;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [7:0]                          s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [15:0]                         m_axis_tdata;
    logic                                m_axis_tuser;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [durs_pkg::CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [durs_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;

    int   errors;
    int   pending;
    int   readings;
    int   saturated;
    logic halted;

    int   ticks_sent = 0;
    int   settings = 0;
    bit   quiet_tx = 1'b0;
    logic echo_lvl [2] = '{1'b0, 1'b0};
    int   echo_left [2] = '{0, 0};

    int   out_beats = 0;
    int   hold_left = 0;
    bit   held = 1'b0;
    int   stall_cycles = 0;
    int   n_long;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    dual_ultrasonic_range_stop_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    range_stop_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_readings  (readings),
        .o_saturated (saturated),
        .o_halted    (halted)
    );

    // Receiver. It stalls at random with a chance of about nine percent, except in
    // one window of output beats where it never stalls. Once, at a fixed
    // output beat count, it holds off for a long stretch so that the block
    // backs up and drops its input ready while the sender keeps offering.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            out_beats <= out_beats + 1;
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!held && out_beats >= HOLD_AT) begin
            held <= 1'b1;
            hold_left <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (out_beats >= RX_QUIET_LO && out_beats < RX_QUIET_HI) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= 9);
        end
    end

    // Watchdog: a run of cycles in which no beat moves on any channel means
    // the block has hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one echo tick and wait until it is taken. The valid is left high
    // so that back-to-back beats never lower and raise it in one time step.
    task automatic send_beat(input logic [1:0] echo);
        begin
            while (!quiet_tx && $urandom_range(99, 0) < 9) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {6'd0, echo};
            do @(posedge i_clk); while (!s_axis_tready);
            ticks_sent++;
        end
    endtask

    // Stop offering and wait until every predicted output beat has come.
    task automatic drain();
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (pending != 0);
        end
    endtask

    task automatic write_reg(input logic [durs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [durs_pkg::CFG_DATA_W-1:0] data);
        begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
    endtask

    // Write all five registers, with random garbage above the narrower ones'
    // widths, then one write to an unused index that the block must ignore.
    task automatic apply_setting(input logic [9:0] thr, input logic [7:0] trig,
                                 input logic [7:0] sgap, input logic [19:0] rgap,
                                 input logic [7:0] tpc);
        begin
            write_reg(durs_pkg::REG_CLOSE_THRESHOLD, {10'($urandom), thr});
            write_reg(durs_pkg::REG_TRIGGER_TICKS, {12'($urandom), trig});
            write_reg(durs_pkg::REG_SENSOR_GAP, {12'($urandom), sgap});
            write_reg(durs_pkg::REG_ROUND_GAP, rgap);
            write_reg(durs_pkg::REG_TICKS_PER_CM, {12'($urandom), tpc});
            write_reg(IDX_W'($urandom_range(IDX_MAX, REG_LAST + 1)), 20'($urandom));
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            settings++;
        end
    endtask

    // Each echo line is a train of low and high runs of random length, with
    // the odd single-tick glitch thrown in as noise.
    task automatic draw_echo(input int max_run, output logic [1:0] echo);
        begin
            for (int k = 0; k < 2; k++) begin
                if (echo_left[k] == 0) begin
                    echo_lvl[k]  = ~echo_lvl[k];
                    echo_left[k] = $urandom_range(max_run, 1);
                end
                echo_left[k]--;
                echo[k] = echo_lvl[k];
                if ($urandom_range(99, 0) < 3) begin
                    echo[k] = ~echo[k];
                end
            end
        end
    endtask

    task automatic run_random(input int n, input int max_run);
        logic [1:0] echo;
        begin
            repeat (n) begin
                draw_echo(max_run, echo);
                send_beat(echo);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Long echo straight after reset, while the sequencer is known to sit
        // at the first trigger. With one tick per cm the count saturates, and
        // the saturated reading sits right at the highest threshold, which is
        // not close. The single low tick completes it; the block is drained
        // before any other reading can complete under that threshold.
        apply_setting(10'd1023, 8'd1, 8'd5, 20'd12, 8'd1);
        n_long = 1030 + $urandom_range(40, 0);
        repeat (n_long) send_beat({1'($urandom), 1'b1});
        send_beat({1'($urandom), 1'b0});
        drain();

        // Directed ticks with every register at zero: trigger length, gaps
        // and ticks per cm of zero, and a zero threshold that is never close.
        apply_setting(10'd0, 8'd0, 8'd0, 20'd0, 8'd0);
        for (int k = 0; k < 24; k++) begin
            send_beat(DIRECTED_TICKS[2*k +: 2]);
        end
        drain();

        // Random rounds. Readings can never be close where the threshold is
        // zero, or one with ticks per cm at one or zero, so ranging goes on.
        apply_setting(10'd0, 8'd255, 8'd255, 20'hFFFFF, 8'd255);
        run_random(80, 300);
        drain();

        apply_setting(10'd1, 8'd1, 8'd0, 20'd3, 8'd1);
        run_random(100, 6);
        drain();

        // A stretch where the sender never idles.
        quiet_tx = 1'b1;
        apply_setting(10'd0, 8'd3, 8'd5, 20'd20, 8'd4);
        run_random(120, 40);
        drain();
        quiet_tx = 1'b0;

        repeat (3) begin
            apply_setting(10'd0, 8'($urandom_range(8, 0)), 8'($urandom_range(12, 0)),
                          20'($urandom_range(40, 0)), 8'($urandom_range(10, 0)));
            run_random(80, $urandom_range(40, 2));
            drain();
        end

        apply_setting(10'd1, 8'd0, 8'd2, 20'd7, 8'd0);
        run_random(60, 5);
        drain();

        // Finally a threshold above anything these short echoes can reach: the
        // first reading is close, the stop flag latches, and the remaining
        // ticks check that the halted block ignores its echo lines.
        apply_setting(10'($urandom_range(60, 20)), 8'd2, 8'd3, 20'd5, 8'd2);
        run_random(100, 30);
        drain();
        repeat (5) @(posedge i_clk);

        $display("Run covered %0d echo ticks under %0d register settings, %0d readings.",
                 ticks_sent, settings, readings);
        $display("Saturated readings: %0d, halted on a close reading: %0s.",
                 saturated, halted ? "yes" : "no");
        if (pending != 0) begin
            $display("%0d predicted output beats never arrived", pending);
        end
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
